@@ src/clcc_pkg.sv @@
// Shared types, constants and the command lookup for the CRLF line command classifier.
package clcc_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int LEN_W = 10;
  localparam int CODE_W = 4;
  localparam int KIND_W = 2;

  // Largest usable limit is one less than the buffer, and the register holds 10 bits.
  localparam int LIMIT_CAP_I = (BUFFER_BYTES - 1 > 1023) ? 1023 : (BUFFER_BYTES - 1);
  localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(LIMIT_CAP_I);
  localparam logic [LEN_W-1:0] MIN_LINE = LEN_W'(5);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [23:0] WORD_TOP = 24'h544F50;
  localparam int NUM_WORDS = 11;

  localparam logic [31:0] CMD_WORDS [NUM_WORDS] = '{
    32'h41504F50, // APOP
    32'h44454C45, // DELE
    32'h4C495354, // LIST
    32'h4E4F4F50, // NOOP
    32'h50415353, // PASS
    32'h51554954, // QUIT
    32'h52455452, // RETR
    32'h52534554, // RSET
    32'h53544154, // STAT
    32'h5549444C, // UIDL
    32'h55534552  // USER
  };

  typedef enum logic [CODE_W-1:0] {
    CMD_NONE = 4'd0,
    CMD_TOP  = 4'd1,
    CMD_APOP = 4'd2
  } cmd_code_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_KNOWN    = 2'd0,
    KIND_UNKNOWN  = 2'd1,
    KIND_TOO_MUCH = 2'd2
  } result_kind_t;

  // One line-end or overflow request passed from the front to the back.
  typedef struct packed {
    logic               ovf;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
  } line_evt_t;

  function automatic logic [CODE_W-1:0] cmd_lookup(input logic [31:0] head,
                                                   input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] code;
    code = CMD_NONE;
    if (len >= MIN_LINE) begin
      if (head[31:8] == WORD_TOP) begin
        code = CMD_TOP;
      end else begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          if (head == CMD_WORDS[i]) code = CODE_W'(CMD_APOP) + CODE_W'(i);
        end
      end
    end
    return code;
  endfunction

endpackage

@@ src/clcc_front.sv @@
// Line framer: tracks length, head bytes, CR state and close state, and raises line requests.
module clcc_front import clcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              accept,
  input  logic              req_type,
  input  logic [7:0]        data_byte,
  output logic              evt_push,
  output line_evt_t         evt
);

  logic [LEN_W-1:0] limit_r, limit_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             last_cr_r, last_cr_nxt;
  logic [31:0]      head_r, head_nxt;
  logic             closed_r, closed_nxt;

  logic [7:0]       folded;
  logic [31:0]      head_upd;
  logic [LEN_W-1:0] count_inc;
  logic             eol;
  logic             ovf;
  logic [CODE_W-1:0] code;

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data > LIMIT_CAP) limit_nxt = LIMIT_CAP;
      else if (cfg_wr_data < MIN_LINE) limit_nxt = MIN_LINE;
      else limit_nxt = cfg_wr_data;
    end
  end

  always_comb begin
    folded = data_byte;
    if (data_byte >= CHAR_LOW_A && data_byte <= CHAR_LOW_Z) folded = data_byte - CASE_OFFSET;

    head_upd = head_r;
    if (count_r[LEN_W-1:2] == '0) begin
      case (count_r[1:0])
        2'd0:    head_upd[31:24] = head_r[31:24] | folded;
        2'd1:    head_upd[23:16] = head_r[23:16] | folded;
        2'd2:    head_upd[15:8]  = head_r[15:8]  | folded;
        2'd3:    head_upd[7:0]   = head_r[7:0]   | folded;
        default: head_upd = head_r;
      endcase
    end

    count_inc = count_r + LEN_W'(1);
    eol = last_cr_r && (data_byte == CHAR_LF);
    ovf = !eol && (count_inc >= limit_r);
    code = cmd_lookup(head_upd, count_inc);

    count_nxt   = count_r;
    last_cr_nxt = last_cr_r;
    head_nxt    = head_r;
    closed_nxt  = closed_r;
    evt_push    = 1'b0;
    evt.ovf     = ovf;
    evt.code    = eol ? code : CODE_W'(CMD_NONE);
    evt.len     = count_inc;

    if (accept) begin
      if (req_type) begin
        count_nxt   = '0;
        last_cr_nxt = 1'b0;
        head_nxt    = '0;
        closed_nxt  = 1'b0;
      end else if (!closed_r) begin
        if (eol || ovf) begin
          evt_push    = 1'b1;
          count_nxt   = '0;
          last_cr_nxt = 1'b0;
          head_nxt    = '0;
          closed_nxt  = ovf || (code == CMD_NONE);
        end else begin
          count_nxt   = count_inc;
          last_cr_nxt = (data_byte == CHAR_CR);
          head_nxt    = head_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_CAP;
      count_r   <= '0;
      last_cr_r <= 1'b0;
      head_r    <= '0;
      closed_r  <= 1'b0;
    end else begin
      limit_r   <= limit_nxt;
      count_r   <= count_nxt;
      last_cr_r <= last_cr_nxt;
      head_r    <= head_nxt;
      closed_r  <= closed_nxt;
    end
  end

endmodule

@@ src/clcc_fifo.sv @@
// Two-entry queue of line requests between the framer and the result stage.
module clcc_fifo import clcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  line_evt_t push_data,
  input  logic      pop,
  output line_evt_t pop_data,
  output logic      empty,
  output logic      full
);

  line_evt_t  mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ src/clcc_back.sv @@
// Result stage: turns a queued line request into a result and holds it in the output register.
module clcc_back import clcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               evt_avail,
  input  line_evt_t          evt,
  output logic               evt_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  result_kind,
  output logic [CODE_W-1:0]  command_code,
  output logic [LEN_W-1:0]   line_length,
  output logic               closing
);

  logic               valid_r, valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               close_r, close_nxt;
  logic               load;

  always_comb begin
    load    = !valid_r || out_ready;
    evt_pop = load && evt_avail;

    valid_nxt = valid_r;
    if (load) valid_nxt = evt_avail;

    if (evt.ovf) kind_nxt = KIND_TOO_MUCH;
    else if (evt.code != CMD_NONE) kind_nxt = KIND_KNOWN;
    else kind_nxt = KIND_UNKNOWN;
    code_nxt  = evt.code;
    len_nxt   = evt.len;
    close_nxt = evt.ovf || (evt.code == CMD_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      kind_r  <= kind_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      close_r <= close_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign result_kind  = kind_r;
  assign command_code = code_r;
  assign line_length  = len_r;
  assign closing      = close_r;

endmodule

@@ src/crlf_line_command_classifier.sv @@
// A line's result goes from the framer into the request queue and then into the output register.
// Throughput: one byte per cycle; the framer keeps taking bytes while a result waits,
// until the two-entry request queue between framer and result stage fills.
// Reset (rst_n low, synchronous): line state and close state clear, the line limit returns
// to 1023, and the queue and output register empty.
module crlf_line_command_classifier import clcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [3:0] command_code, [13:4] line_length, [14] closing
  output logic [KIND_W-1:0] out_tuser   // [1:0] result_kind
);

  logic       in_accept;
  logic       evt_push;
  line_evt_t  evt_in;
  line_evt_t  evt_out;
  logic       evt_pop;
  logic       q_empty;
  logic       q_full;
  logic [CODE_W-1:0] command_code;
  logic [LEN_W-1:0]  line_length;
  logic              closing;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  clcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_accept),
    .req_type    (in_tuser),
    .data_byte   (in_tdata),
    .evt_push    (evt_push),
    .evt         (evt_in)
  );

  clcc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_data (evt_in),
    .pop       (evt_pop),
    .pop_data  (evt_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  clcc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt_avail    (!q_empty),
    .evt          (evt_out),
    .evt_pop      (evt_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .result_kind  (out_tuser),
    .command_code (command_code),
    .line_length  (line_length),
    .closing      (closing)
  );

  assign out_tdata = {1'b0, closing, line_length, command_code};

endmodule

@@ src/clcc_checker.sv @@
// Port-level checks for the CRLF line command classifier, bound to the top level.
module clcc_checker import clcc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [15:0]       out_tdata,
  input logic [KIND_W-1:0] out_tuser
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A known line carries a command code and keeps the connection open.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_KNOWN |-> out_tdata[3:0] != CMD_NONE && !out_tdata[14])
    else $error("known line without code or with close");

  // Unknown lines and overflow carry no code and always close.
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_UNKNOWN || out_tuser == KIND_TOO_MUCH)
      |-> out_tdata[3:0] == CMD_NONE && out_tdata[14])
    else $error("rejected line with code or without close");

  // A known line is at least five bytes long and the code stays in range.
  a_known_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_KNOWN
      |-> out_tdata[13:4] >= MIN_LINE && out_tdata[3:0] <= CODE_W'(12))
    else $error("known line too short or code out of range");

endmodule

bind crlf_line_command_classifier clcc_checker u_clcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the CRLF line command classifier, driven and checked over its streams.
`timescale 1ns / 100ps

module tb_top;
  import clcc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    PC_NONE, PC_TOP, PC_APOP, PC_DELE, PC_LIST, PC_NOOP, PC_PASS,
    PC_QUIT, PC_RETR, PC_RSET, PC_STAT, PC_UIDL, PC_USER
  } pop_cmd_t;

  // Text of each command, first character in the top byte; TOP only uses its top three bytes.
  localparam logic [31:0] COMMAND_TEXT [13] = '{
    32'h0, "TOP ", "APOP", "DELE", "LIST", "NOOP", "PASS",
    "QUIT", "RETR", "RSET", "STAT", "UIDL", "USER"
  };

  typedef struct packed {
    logic       reconnect;
    logic [7:0] value;
  } rx_item_t;

  typedef struct packed {
    result_kind_t      kind;
    pop_cmd_t          code;
    logic [LEN_W-1:0]  len;
    logic              closing;
  } line_verdict_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic [KIND_W-1:0] out_tuser;

  crlf_line_command_classifier i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #5 clk = ~clk;

  rx_item_t      byte_stream [$];
  line_verdict_t pending_verdicts [$];
  rx_item_t      cur_item;

  // Mirror of the block's line state and limit register.
  logic [LEN_W-1:0] line_count = '0;
  logic             saw_cr = 1'b0;
  logic [31:0]      head_text = '0;
  logic             conn_closed = 1'b0;
  logic [LEN_W-1:0] limit_reg = LIMIT_CAP;

  int accepted_cnt = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int idle_odds = 4;
  int gen_limit = 1023;
  int settings_cnt = 1;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  function automatic int effective_limit();
    logic [LEN_W-1:0] lim;
    lim = limit_reg;
    if (lim > LIMIT_CAP) lim = LIMIT_CAP;
    if (lim < MIN_LINE) lim = MIN_LINE;
    return int'(lim);
  endfunction

  function automatic pop_cmd_t match_command(input logic [LEN_W-1:0] len,
                                             input logic [31:0] head);
    pop_cmd_t code;
    code = PC_NONE;
    if (len >= MIN_LINE) begin
      if (head[31:8] == COMMAND_TEXT[PC_TOP][31:8]) begin
        code = PC_TOP;
      end else begin
        for (int i = PC_APOP; i <= PC_USER; i++) begin
          if (head == COMMAND_TEXT[i]) code = pop_cmd_t'(i);
        end
      end
    end
    return code;
  endfunction

  task automatic clear_line();
    line_count = '0;
    saw_cr = 1'b0;
    head_text = '0;
  endtask

  // Advances the mirrored state by one accepted request and queues any result it causes.
  task automatic take_request(input rx_item_t item);
    logic [7:0]    folded;
    line_verdict_t v;
    int            pos;
    if (item.reconnect) begin
      clear_line();
      conn_closed = 1'b0;
      return;
    end
    if (conn_closed) return;
    folded = (item.value >= "a" && item.value <= "z") ? item.value - 8'h20 : item.value;
    pos = int'(line_count);
    if (pos < 4) head_text[31 - 8 * pos -: 8] = folded;
    line_count = line_count + 1'b1;
    if (saw_cr && item.value == CHAR_LF) begin
      v.code = match_command(line_count, head_text);
      v.kind = (v.code != PC_NONE) ? KIND_KNOWN : KIND_UNKNOWN;
      v.len = line_count;
      v.closing = (v.code == PC_NONE);
      conn_closed = v.closing;
      pending_verdicts.push_back(v);
      clear_line();
      return;
    end
    saw_cr = (item.value == CHAR_CR);
    if (int'(line_count) >= effective_limit()) begin
      v.kind = KIND_TOO_MUCH;
      v.code = PC_NONE;
      v.len = line_count;
      v.closing = 1'b1;
      conn_closed = 1'b1;
      pending_verdicts.push_back(v);
      clear_line();
    end
  endtask

  task automatic flag_mismatch(input string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_request(cur_item);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          cur_item = byte_stream.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur_item.value;
          in_tuser <= cur_item.reconnect;
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) tx_gap = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt >= 150) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver.
  always @(posedge clk) begin
    line_verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          flag_mismatch($sformatf("result with no line pending (tdata %h tuser %h)",
                                  out_tdata, out_tuser));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tuser != want.kind)
            flag_mismatch($sformatf("result_kind %0d, expected %0d", out_tuser, want.kind));
          if (out_tdata[3:0] != want.code)
            flag_mismatch($sformatf("command_code %0d, expected %0d", out_tdata[3:0], want.code));
          if (out_tdata[13:4] != want.len)
            flag_mismatch($sformatf("line_length %0d, expected %0d", out_tdata[13:4], want.len));
          if (out_tdata[14] != want.closing)
            flag_mismatch($sformatf("closing %0b, expected %0b", out_tdata[14], want.closing));
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) rx_gap = $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] value);
    byte_stream.push_back('{reconnect: 1'b0, value: value});
  endtask

  task automatic push_reconnect();
    byte_stream.push_back('{reconnect: 1'b1, value: 8'($urandom_range(0, 255))});
  endtask

  task automatic push_text(input string s, input bit crlf);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    if (crlf) begin
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
    end
  endtask

  function automatic logic [7:0] random_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) return c + 8'h20;
    return c;
  endfunction

  // Appends one line: mostly a command with random case and tail, sometimes junk.
  task automatic queue_line();
    int          pick;
    int          head_len;
    int          tail_len;
    int          cmd;
    logic [31:0] text;
    bit          bad;
    bit          near;
    pick = $urandom_range(0, 99);
    bad = 1'b0;
    near = 1'b0;
    head_len = 0;
    if (pick < 72) begin
      cmd = $urandom_range(PC_TOP, PC_USER);
      text = COMMAND_TEXT[cmd];
      head_len = (cmd == PC_TOP) ? 3 : 4;
      for (int i = 0; i < head_len; i++) push_byte(random_case(text[31 - 8 * i -: 8]));
    end else if (pick < 90) begin
      head_len = $urandom_range(0, 5);
      for (int i = 0; i < head_len; i++) begin
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)));
        else push_byte(random_case(8'($urandom_range("A", "Z"))));
      end
      bad = 1'b1;
    end else begin
      // A run of raw bytes with no line end, often cut short by a new connection.
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) push_reconnect();
      return;
    end
    if (gen_limit <= 64 && $urandom_range(0, 5) == 0) begin
      tail_len = gen_limit - head_len - 2 + $urandom_range(0, 2) - 1;
      if (tail_len < 0) tail_len = 0;
      near = 1'b1;
    end else begin
      tail_len = $urandom_range(0, 6);
    end
    repeat (tail_len) begin
      if ($urandom_range(0, 15) == 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(8'($urandom_range(32, 126)));
    end
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    if ((bad || near) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0))
      push_reconnect();
  endtask

  task automatic drain();
    while (byte_stream.size() != 0 || in_tvalid || pending_verdicts.size() != 0)
      @(negedge clk);
    // Let any line still in the framer settle before the next register write.
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
    gen_limit = effective_limit();
    settings_cnt++;
    @(negedge clk);
  endtask

  task automatic fill_random(input int budget);
    int start;
    start = byte_stream.size();
    while (byte_stream.size() - start < budget) queue_line();
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] limit, input int budget, input int odds);
    write_limit(limit);
    idle_odds = odds;
    fill_random(budget);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default limit: lower-case command, bare TOP, a short line holding a NUL,
    // a byte sent while closed, then a new connection.
    push_text("quit", 1'b1);
    push_text("TOP", 1'b1);
    push_byte("a");
    push_byte(8'h00);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_byte("Z");
    push_reconnect();
    drain();

    // A limit below the minimum acts as five: a CRLF landing on the limit still
    // classifies, and five bytes without one overflow.
    write_limit(10'd3);
    push_text("TOP", 1'b1);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_byte(8'h00);
    push_byte(8'hAA);
    push_reconnect();
    fill_random(100);
    drain();

    run_phase(10'd12, 100, 4);

    // A long limit with one line that runs all the way to it.
    write_limit(10'd300);
    idle_odds = 3;
    repeat (300) begin
      logic [7:0] fill;
      fill = 8'($urandom_range(0, 255));
      push_byte(fill == CHAR_CR ? 8'h0E : fill);
    end
    push_reconnect();
    fill_random(50);
    drain();

    run_phase(10'd0, 60, 0);
    run_phase(10'd40, 70, 5);
    run_phase(10'd5, 60, 3);
    run_phase(10'd200, 60, 0);

    $display("Covered %0d requests and %0d line results over %0d limit settings,",
             accepted_cnt, results_seen, settings_cnt);
    $display("with random stalls on both sides and one long receiver hold-off.");
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
